[hw/rtl/npe_pkg.sv]
// Shared types, constants and helper functions for the NMEA position extractor.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package npe_pkg;

   // Default number of characters buffered for each value field.
   localparam int DEFAULT_FIELD_CHARS = 16;

   // Length counters must hold any field size up to the largest supported buffer.
   localparam int LEN_W = 5;

   // Depth of the command queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_LATITUDE_FIELD  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LONGITUDE_FIELD = 1'd1;

   localparam logic [CSR_DATA_W-1:0] RESET_LATITUDE_FIELD  = 4'd2;
   localparam logic [CSR_DATA_W-1:0] RESET_LONGITUDE_FIELD = 4'd4;
   localparam logic [CSR_DATA_W-1:0] FIELD_INDEX_MAX       = 4'd15;

   // Framing characters.
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UC_A   = 8'h41;
   localparam logic [7:0] CHAR_UC_F   = 8'h46;
   localparam logic [7:0] CHAR_LC_A   = 8'h61;
   localparam logic [7:0] CHAR_LC_F   = 8'h66;

   // Result field kinds.
   localparam logic [1:0] KIND_LAT_CHAR = 2'd0;
   localparam logic [1:0] KIND_LAT_HEMI = 2'd1;
   localparam logic [1:0] KIND_LON_CHAR = 2'd2;
   localparam logic [1:0] KIND_LON_HEMI = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // One finished sentence, as handed from the front part to the back part.
   typedef struct packed {
      logic             is_run;
      logic [1:0]       status;
      logic [LEN_W-1:0] lat_len;
      logic [LEN_W-1:0] lon_len;
      logic [7:0]       lat_hemi;
      logic [7:0]       lon_hemi;
   } cmd_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // Decodes one hex digit in either case. Digits and letters share the low
   // nibble pattern, letters just sit nine above it.
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b0;
      h.value = c[3:0];
      if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         h.ok = 1'b1;
      end else if (c inside {[CHAR_UC_A:CHAR_UC_F], [CHAR_LC_A:CHAR_LC_F]}) begin
         h.ok    = 1'b1;
         h.value = c[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/npe_front.sv]
// Front part of the NMEA position extractor: byte parser, configuration
// registers and the two value buffers. Depends on npe_pkg.
`default_nettype none

module npe_front #(
   parameter int FIELD_CHARS = npe_pkg::DEFAULT_FIELD_CHARS,
   localparam int IDX_W = $clog2(FIELD_CHARS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [7:0]                          req_rx_byte,
   output logic                                req_stall,
   input  logic                                csr_write_enable,
   input  logic [npe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [npe_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                queue_full,
   output logic                                push,
   output npe_pkg::cmd_type                    push_cmd,
   input  logic                                run_done,
   input  logic [IDX_W-1:0]                    rd_idx,
   output logic [7:0]                          lat_rd_char,
   output logic [7:0]                          lon_rd_char
);
   import npe_pkg::*;

   localparam logic [1:0] PH_BODY = 2'd0;
   localparam logic [1:0] PH_HIGH = 2'd1;
   localparam logic [1:0] PH_LOW  = 2'd2;

   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(FIELD_CHARS);

   logic [CSR_DATA_W-1:0] lat_field_ff, lat_field_in;
   logic [CSR_DATA_W-1:0] lon_field_ff, lon_field_in;
   logic                  in_sentence_ff, in_sentence_in;
   logic [1:0]            phase_ff, phase_in;
   logic [7:0]            xor_ff, xor_in;
   logic [3:0]            nibble_ff, nibble_in;
   logic [3:0]            field_idx_ff, field_idx_in;
   logic [LEN_W-1:0]      lat_len_ff, lat_len_in;
   logic [LEN_W-1:0]      lon_len_ff, lon_len_in;
   logic [7:0]            lat_hemi_ff, lat_hemi_in;
   logic [7:0]            lon_hemi_ff, lon_hemi_in;
   logic [1:0]            err_ff, err_in;
   logic                  run_busy_ff, run_busy_in;
   logic [7:0]            lat_chars_ff [FIELD_CHARS];
   logic [7:0]            lon_chars_ff [FIELD_CHARS];

   logic    accept;
   logic    lat_wr;
   logic    lon_wr;
   hex_type hex;
   logic [7:0] rx;

   assign req_stall   = queue_full | run_busy_ff;
   assign accept      = req_valid & ~req_stall;
   assign rx          = req_rx_byte;
   assign hex         = hex_decode(rx);
   assign lat_rd_char = lat_chars_ff[rd_idx];
   assign lon_rd_char = lon_chars_ff[rd_idx];

   always_comb begin
      lat_field_in   = lat_field_ff;
      lon_field_in   = lon_field_ff;
      in_sentence_in = in_sentence_ff;
      phase_in       = phase_ff;
      xor_in         = xor_ff;
      nibble_in      = nibble_ff;
      field_idx_in   = field_idx_ff;
      lat_len_in     = lat_len_ff;
      lon_len_in     = lon_len_ff;
      lat_hemi_in    = lat_hemi_ff;
      lon_hemi_in    = lon_hemi_ff;
      err_in         = err_ff;
      run_busy_in    = run_busy_ff;
      lat_wr         = 1'b0;
      lon_wr         = 1'b0;
      push           = 1'b0;
      push_cmd.is_run   = 1'b0;
      push_cmd.status   = STATUS_CHECKSUM;
      push_cmd.lat_len  = lat_len_ff;
      push_cmd.lon_len  = lon_len_ff;
      push_cmd.lat_hemi = lat_hemi_ff;
      push_cmd.lon_hemi = lon_hemi_ff;

      if (csr_write_enable) begin
         case (csr_index)
            REG_LATITUDE_FIELD:  lat_field_in = csr_write_data;
            REG_LONGITUDE_FIELD: lon_field_in = csr_write_data;
            default: ;
         endcase
      end

      if (run_done) begin
         run_busy_in = 1'b0;
      end

      if (accept) begin
         if (rx == CHAR_DOLLAR) begin
            in_sentence_in = 1'b1;
            phase_in       = PH_BODY;
            xor_in         = '0;
            nibble_in      = '0;
            field_idx_in   = '0;
            lat_len_in     = '0;
            lon_len_in     = '0;
            lat_hemi_in    = '0;
            lon_hemi_in    = '0;
            err_in         = '0;
         end else if (in_sentence_ff) begin
            case (phase_ff)
               PH_BODY: begin
                  if (rx == CHAR_STAR) begin
                     phase_in = PH_HIGH;
                  end else begin
                     xor_in = xor_ff ^ rx;
                     if (rx == CHAR_COMMA) begin
                        if (field_idx_ff != FIELD_INDEX_MAX) begin
                           field_idx_in = field_idx_ff + 4'd1;
                        end
                     end else begin
                        if (field_idx_ff == lat_field_ff) begin
                           if (lat_len_ff < FULL_LEN) begin
                              lat_wr     = 1'b1;
                              lat_len_in = lat_len_ff + 1'b1;
                           end else begin
                              err_in[0] = 1'b1;
                           end
                        end
                        // The hemisphere field number can be 16, which no
                        // saturated field count ever reaches.
                        if ({1'b0, field_idx_ff} == {1'b0, lat_field_ff} + 5'd1) begin
                           lat_hemi_in = rx;
                        end
                        if (field_idx_ff == lon_field_ff) begin
                           if (lon_len_ff < FULL_LEN) begin
                              lon_wr     = 1'b1;
                              lon_len_in = lon_len_ff + 1'b1;
                           end else begin
                              err_in[1] = 1'b1;
                           end
                        end
                        if ({1'b0, field_idx_ff} == {1'b0, lon_field_ff} + 5'd1) begin
                           lon_hemi_in = rx;
                        end
                     end
                  end
               end
               PH_HIGH: begin
                  if (hex.ok) begin
                     nibble_in = hex.value;
                     phase_in  = PH_LOW;
                  end else begin
                     in_sentence_in = 1'b0;
                     phase_in       = PH_BODY;
                     push           = 1'b1;
                  end
               end
               PH_LOW: begin
                  in_sentence_in = 1'b0;
                  phase_in       = PH_BODY;
                  push           = 1'b1;
                  if (!hex.ok || {nibble_ff, hex.value} != xor_ff) begin
                     push_cmd.status = STATUS_CHECKSUM;
                  end else if (err_ff != 2'b00) begin
                     push_cmd.status = STATUS_OVERFLOW;
                  end else begin
                     push_cmd.is_run = 1'b1;
                     push_cmd.status = STATUS_OK;
                     run_busy_in     = 1'b1;
                  end
               end
               default: phase_in = PH_BODY;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_field_ff   <= RESET_LATITUDE_FIELD;
         lon_field_ff   <= RESET_LONGITUDE_FIELD;
         in_sentence_ff <= 1'b0;
         phase_ff       <= PH_BODY;
         xor_ff         <= '0;
         nibble_ff      <= '0;
         field_idx_ff   <= '0;
         lat_len_ff     <= '0;
         lon_len_ff     <= '0;
         lat_hemi_ff    <= '0;
         lon_hemi_ff    <= '0;
         err_ff         <= '0;
         run_busy_ff    <= 1'b0;
      end else begin
         lat_field_ff   <= lat_field_in;
         lon_field_ff   <= lon_field_in;
         in_sentence_ff <= in_sentence_in;
         phase_ff       <= phase_in;
         xor_ff         <= xor_in;
         nibble_ff      <= nibble_in;
         field_idx_ff   <= field_idx_in;
         lat_len_ff     <= lat_len_in;
         lon_len_ff     <= lon_len_in;
         lat_hemi_ff    <= lat_hemi_in;
         lon_hemi_ff    <= lon_hemi_in;
         err_ff         <= err_in;
         run_busy_ff    <= run_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lat_wr) begin
         lat_chars_ff[lat_len_ff[IDX_W-1:0]] <= rx;
      end
      if (lon_wr) begin
         lon_chars_ff[lon_len_ff[IDX_W-1:0]] <= rx;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/npe_queue.sv]
// Small command queue between the parser and the result sequencer.
// Depends on npe_pkg for the command type.
`default_nettype none

module npe_queue #(
   parameter int DEPTH = npe_pkg::QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  npe_pkg::cmd_type push_cmd,
   input  logic             pop,
   output npe_pkg::cmd_type head,
   output logic             full,
   output logic             empty
);
   import npe_pkg::*;

   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/npe_back.sv]
// Back part of the NMEA position extractor: turns queued commands into result
// words through a registered output stage. Depends on npe_pkg.
`default_nettype none

module npe_back #(
   parameter int FIELD_CHARS = npe_pkg::DEFAULT_FIELD_CHARS,
   localparam int IDX_W = $clog2(FIELD_CHARS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  npe_pkg::cmd_type queue_head,
   output logic             pop,
   output logic             run_done,
   output logic [IDX_W-1:0] rd_idx,
   input  logic [7:0]       lat_rd_char,
   input  logic [7:0]       lon_rd_char,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_field_kind,
   output logic [7:0]       rsp_character,
   output logic [1:0]       rsp_status,
   output logic             rsp_last
);
   import npe_pkg::*;

   localparam logic [2:0] SEQ_IDLE = 3'd0;
   localparam logic [2:0] SEQ_LAT  = 3'd1;
   localparam logic [2:0] SEQ_LATH = 3'd2;
   localparam logic [2:0] SEQ_LON  = 3'd3;
   localparam logic [2:0] SEQ_LONH = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   cmd_type          cmd_ff, cmd_in;
   logic             valid_ff, valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       char_ff, char_in;
   logic [1:0]       status_ff, status_in;
   logic             last_ff, last_in;

   logic             load;
   logic [LEN_W-1:0] idx_next;

   assign load     = ~valid_ff | ~rsp_stall;
   assign idx_next = LEN_W'(idx_ff) + 1'b1;
   assign rd_idx   = idx_ff;

   assign rsp_valid      = valid_ff;
   assign rsp_field_kind = kind_ff;
   assign rsp_character  = char_ff;
   assign rsp_status     = status_ff;
   assign rsp_last       = last_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      char_in   = char_ff;
      status_in = status_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      run_done  = 1'b0;

      if (load) begin
         valid_in  = 1'b0;
         status_in = STATUS_OK;
         last_in   = 1'b0;
         case (state_ff)
            SEQ_IDLE: begin
               if (!queue_empty) begin
                  pop = 1'b1;
                  if (queue_head.is_run) begin
                     cmd_in   = queue_head;
                     idx_in   = '0;
                     state_in = (queue_head.lat_len != '0) ? SEQ_LAT : SEQ_LATH;
                  end else begin
                     valid_in  = 1'b1;
                     kind_in   = KIND_LAT_CHAR;
                     char_in   = '0;
                     status_in = queue_head.status;
                     last_in   = 1'b1;
                  end
               end
            end
            SEQ_LAT: begin
               valid_in = 1'b1;
               kind_in  = KIND_LAT_CHAR;
               char_in  = lat_rd_char;
               if (idx_next == cmd_ff.lat_len) begin
                  idx_in   = '0;
                  state_in = SEQ_LATH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            SEQ_LATH: begin
               valid_in = 1'b1;
               kind_in  = KIND_LAT_HEMI;
               char_in  = cmd_ff.lat_hemi;
               state_in = (cmd_ff.lon_len != '0) ? SEQ_LON : SEQ_LONH;
            end
            SEQ_LON: begin
               valid_in = 1'b1;
               kind_in  = KIND_LON_CHAR;
               char_in  = lon_rd_char;
               if (idx_next == cmd_ff.lon_len) begin
                  idx_in   = '0;
                  state_in = SEQ_LONH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            SEQ_LONH: begin
               valid_in = 1'b1;
               kind_in  = KIND_LON_HEMI;
               char_in  = cmd_ff.lon_hemi;
               last_in  = 1'b1;
               run_done = 1'b1;
               state_in = SEQ_IDLE;
            end
            default: state_in = SEQ_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      kind_ff   <= kind_in;
      char_ff   <= char_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

endmodule

`default_nettype wire

[hw/rtl/nmea_position_extractor_core.sv]
// NMEA position extractor: parses a GPS byte stream and returns latitude and
// longitude text. Top level; instantiates npe_front, npe_queue and npe_back.
//
// Usage:
//   Received bytes enter on the req_ channel, one word per byte. A '$' opens a
//   sentence; bytes up to '*' are checksummed and split at commas, and the
//   configured latitude and longitude fields (plus the hemisphere field after
//   each) are buffered. The two hex digits after '*' close the sentence.
//   Results leave on the rsp_ channel. A good sentence yields a run of words:
//   latitude characters, latitude hemisphere, longitude characters, longitude
//   hemisphere, with rsp_last on the final one. A checksum mismatch, a bad hex
//   digit or an overflowing field yields a single status word instead.
//   The csr_ port selects the two field numbers; write it only while idle.
// Timing:
//   Bytes are taken one per cycle while req_stall is low. A status word passes
//   through the command queue and the output register; the first word of a run
//   passes through the command queue, the sequencer state register and the output
//   register. The input stalls from the byte that ends a good sentence until its
//   run is done, because the run reads the field buffers that the next sentence would overwrite.
// Reset and stalls:
//   Reset clears the parser, the command queue and the output register, and
//   restores the default field numbers. When the receiver stalls, the output
//   word holds; the parser keeps taking bytes until the command queue fills or a run holds the input.
`default_nettype none

module nmea_position_extractor_core #(
   parameter int FIELD_CHARS = npe_pkg::DEFAULT_FIELD_CHARS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_field_kind,
   output logic [7:0]                      rsp_character,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_last,
   input  logic                            csr_write_enable,
   input  logic [npe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [npe_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import npe_pkg::*;

   localparam int IDX_W = $clog2(FIELD_CHARS);

   // Parser to queue.
   logic    push;
   cmd_type push_cmd;

   // Queue to sequencer.
   logic    queue_full;
   logic    queue_empty;
   logic    pop;
   cmd_type queue_head;

   // Sequencer back to the parser: buffer read and end of run.
   logic             run_done;
   logic [IDX_W-1:0] rd_idx;
   logic [7:0]       lat_rd_char;
   logic [7:0]       lon_rd_char;

   npe_front #(
      .FIELD_CHARS(FIELD_CHARS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_rx_byte      (req_rx_byte),
      .req_stall        (req_stall),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push             (push),
      .push_cmd         (push_cmd),
      .run_done         (run_done),
      .rd_idx           (rd_idx),
      .lat_rd_char      (lat_rd_char),
      .lon_rd_char      (lon_rd_char)
   );

   npe_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (queue_head),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   npe_back #(
      .FIELD_CHARS(FIELD_CHARS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_empty    (queue_empty),
      .queue_head     (queue_head),
      .pop            (pop),
      .run_done       (run_done),
      .rd_idx         (rd_idx),
      .lat_rd_char    (lat_rd_char),
      .lon_rd_char    (lon_rd_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_field_kind (rsp_field_kind),
      .rsp_character  (rsp_character),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

[hw/rtl/npe_checker.sv]
// Port-level assertions for the NMEA position extractor, bound to the top level.
// Depends on npe_pkg and nmea_position_extractor_core.
`default_nettype none

module npe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_field_kind,
   input logic [7:0] rsp_character,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);
   import npe_pkg::*;

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_field_kind)
         && $stable(rsp_character) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // Nothing is presented right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Status words stand alone and carry no character.
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_last && rsp_character == 8'd0 && rsp_field_kind == KIND_LAT_CHAR)
      else $error("malformed status word");

   // A good run ends exactly on the longitude hemisphere word.
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
         (rsp_last == (rsp_field_kind == KIND_LON_HEMI)))
      else $error("run end marker misplaced");

   // After the latitude hemisphere word is taken, the output register already
   // holds the next word of the same run, which is longitude data.
   a_run_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_field_kind == KIND_LAT_HEMI
         && rsp_status == STATUS_OK |=>
         !rsp_valid || rsp_field_kind == KIND_LON_CHAR
         || rsp_field_kind == KIND_LON_HEMI)
      else $error("latitude hemisphere not followed by longitude data");

endmodule

bind nmea_position_extractor_core npe_checker u_npe_checker (.*);

`default_nettype wire
